>>> rtl/core/iirdf1_pkg.sv
// ----------------------------------------------------------------------------
// iirdf1_pkg: shared types and constants for the direct form I IIR filter
// Sample, coefficient and accumulator formats, register indexes and the
// bundles passed between the filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package iirdf1_pkg;

    // Filter order and data formats
    localparam int ORDER        = 2;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 16;

    // Register map: forward b0..bN, then feedback a1..aN
    localparam int NUM_REGS      = 2 * ORDER + 1;
    localparam int CFG_IDX_W     = $clog2(NUM_REGS);
    localparam int FWD_COEF_BASE = 0;
    localparam int FBK_COEF_BASE = ORDER + 1;

    // Arithmetic widths: products, exact sum, value after the rounding shift
    localparam int FRAC_SHIFT = COEF_WIDTH - 2;
    localparam int PROD_W     = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W      = PROD_W + $clog2(NUM_REGS);
    localparam int RND_W      = ACC_W - FRAC_SHIFT;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [ACC_W-1:0]        acc_t;
    typedef logic signed [RND_W-1:0]        rnd_t;
    typedef logic [CFG_IDX_W-1:0]           cfg_idx_t;

    // Saturation limits
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Reset value of the current-input coefficient: one in Q2.x
    localparam coef_t COEF_ONE = coef_t'(1) <<< FRAC_SHIFT;

    // Full coefficient set
    typedef struct packed {
        coef_t [ORDER:0] fwd;
        coef_t [ORDER:1] fbk;
    } coef_set_t;

    // One filtered result
    typedef struct packed {
        sample_t sample;
        logic    clipped;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/iirdf1_coef_regs.sv
// ----------------------------------------------------------------------------
// iirdf1_coef_regs: coefficient register file
// Holds the forward and feedback coefficients; writes to an index beyond the
// register map are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module iirdf1_coef_regs
    import iirdf1_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_write,
    input  wire cfg_idx_t  cfg_index,
    input  wire coef_t     cfg_data,
    output coef_set_t      coefs
);

    // Unity pass-through: b0 = one, every other coefficient zero
    localparam coef_set_t COEFS_RESET = '{
        fwd: {{(ORDER*COEF_WIDTH){1'b0}}, COEF_ONE},
        fbk: '0
    };

    coef_set_t coefs_reg;
    coef_set_t coefs_next;

    // Decode the write index into the coefficient set
    always_comb
    begin
        coefs_next = coefs_reg;
        if (cfg_write)
        begin
            for (int i = 0; i <= ORDER; i++)
            begin
                if (cfg_index == cfg_idx_t'(FWD_COEF_BASE + i))
                begin
                    coefs_next.fwd[i] = cfg_data;
                end
            end
            for (int i = 1; i <= ORDER; i++)
            begin
                if (cfg_index == cfg_idx_t'(FBK_COEF_BASE + i - 1))
                begin
                    coefs_next.fbk[i] = cfg_data;
                end
            end
        end
    end

    // Hold coefficients; reset to a unity pass-through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg <= COEFS_RESET;
        end
        else
        begin
            coefs_reg <= coefs_next;
        end
    end

    assign coefs = coefs_reg;

endmodule

`default_nettype wire

>>> rtl/core/iirdf1_datapath.sv
// ----------------------------------------------------------------------------
// iirdf1_datapath: multiply-accumulate, rounding and saturation
// Forms one output from the current sample and the input/output histories,
// and advances the histories when a sample is processed.
// ----------------------------------------------------------------------------
`default_nettype none

module iirdf1_datapath
    import iirdf1_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,
    input  wire sample_t   u,
    input  wire coef_set_t coefs,
    output result_t        result
);

    sample_t in_hist_reg  [ORDER];
    sample_t out_hist_reg [ORDER];

    prod_t   prod_cur;
    prod_t   prod_fwd [ORDER];
    prod_t   prod_fbk [ORDER];
    acc_t    acc;
    acc_t    acc_half;
    rnd_t    rnd;
    logic [RND_W-SAMPLE_WIDTH:0] rnd_top;
    logic    in_range;

    localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_SHIFT - 1);

    // Products, all taps in parallel
    always_comb
    begin
        prod_cur = coefs.fwd[0] * u;
        for (int i = 0; i < ORDER; i++)
        begin
            prod_fwd[i] = $signed(coefs.fwd[i+1]) * in_hist_reg[i];
            prod_fbk[i] = $signed(coefs.fbk[i+1]) * out_hist_reg[i];
        end
    end

    // Exact sum, round half up, saturate
    always_comb
    begin
        acc = acc_t'(prod_cur);
        for (int i = 0; i < ORDER; i++)
        begin
            acc = acc + acc_t'(prod_fwd[i]) - acc_t'(prod_fbk[i]);
        end
        acc_half = acc + ROUND_HALF;
        rnd      = rnd_t'(acc_half >>> FRAC_SHIFT);
        rnd_top  = rnd[RND_W-1:SAMPLE_WIDTH-1];
        in_range = (&rnd_top) || !(|rnd_top);

        if (in_range)
        begin
            result.sample  = rnd[SAMPLE_WIDTH-1:0];
            result.clipped = 1'b0;
        end
        else
        begin
            result.sample  = rnd[RND_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
            result.clipped = 1'b1;
        end
    end

    // Advance histories: newest at slot 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ORDER; i++)
            begin
                in_hist_reg[i]  <= '0;
                out_hist_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            in_hist_reg[0]  <= u;
            out_hist_reg[0] <= result.sample;
            for (int i = 1; i < ORDER; i++)
            begin
                in_hist_reg[i]  <= in_hist_reg[i-1];
                out_hist_reg[i] <= out_hist_reg[i-1];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/iir_direct_form_one_filter.sv
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter: direct form I IIR filter, top level
// Registers each input request, filters it combinationally against the sample
// histories and holds the result in an output register.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------
//  input    | in        | in_valid / in_ready  | sample_in
//  output   | out       | out_valid / out_ready| sample_out, clipped
//  config   | in        | cfg_write (no wait)  | cfg_index, cfg_data
//
//  One sample per clock sustained while the output is not stalled; each accepted
//  request is held in the input register and its result in the output register,
//  from which it is taken. The combinational feedback path (one multiply
//  plus the five-term sum, rounding and saturation) sets the clock rate.
//  Reset clears the histories and loads a unity pass-through (b0 = 1).
//  While the output is stalled, one more request is taken into the input
//  register; after that in_ready drops until the output is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_direct_form_one_filter
    import iirdf1_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire sample_t  sample_in,
    output logic          out_valid,
    input  wire logic     out_ready,
    output sample_t       sample_out,
    output logic          clipped,
    input  wire logic     cfg_write,
    input  wire cfg_idx_t cfg_index,
    input  wire coef_t    cfg_data
);

    logic      in_valid_reg;
    sample_t   in_sample_reg;
    logic      out_valid_reg;
    result_t   out_result_reg;
    logic      fire;
    coef_set_t coefs;
    result_t   result;

    // Process the held request when the output register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    iirdf1_coef_regs u_coef_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    iirdf1_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (fire),
        .u       (in_sample_reg),
        .coefs   (coefs),
        .result  (result)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: capture on accept, hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_sample_reg <= sample_in;
        end
        if (fire)
        begin
            out_result_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_result_reg.sample;
    assign clipped    = out_result_reg.clipped;

endmodule

`default_nettype wire

>>> rtl/core/iirdf1_checker.sv
// ----------------------------------------------------------------------------
// iirdf1_checker: port-level checks for the IIR filter
// Watches the top-level handshakes and result flags over time.
// ----------------------------------------------------------------------------
`default_nettype none

module iirdf1_checker
    import iirdf1_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    in_valid,
    input wire logic    in_ready,
    input wire logic    out_valid,
    input wire logic    out_ready,
    input wire sample_t sample_out,
    input wire logic    clipped
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(clipped))
        else $error("stalled result changed");

    // Clipped result sits at a limit
    a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> sample_out == SAMPLE_MAX || sample_out == SAMPLE_MIN)
        else $error("clipped result not at a saturation limit");

    // Empty output register never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // Request taken with empty output passes through the input and output registers to a valid output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid)
        else $error("accepted request produced no result");

endmodule

bind iir_direct_form_one_filter iirdf1_checker u_iirdf1_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .clipped    (clipped)
);

`default_nettype wire
